>>> hdl/sha1_pkg.sv
// Shared types and constants of the SHA-1 hash engine.
package sha1_pkg;

  // Sequencer states of the engine.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ABSORB,
    ST_ZERO,
    ST_LEN,
    ST_ROUND,
    ST_FINISH,
    ST_OUT
  } sha1_state_t;

  // Round constants, one for each group of twenty rounds.
  localparam logic [31:0] K_R0 = 32'h5a82_7999;
  localparam logic [31:0] K_R1 = 32'h6ed9_eba1;
  localparam logic [31:0] K_R2 = 32'h8f1b_bcdc;
  localparam logic [31:0] K_R3 = 32'hca62_c1d6;

  // Initial chaining values.
  localparam int unsigned CHAIN_WORDS = 5;
  localparam logic [31:0] H_INIT [CHAIN_WORDS] = '{
    32'h6745_2301, 32'hefcd_ab89, 32'h98ba_dcfe, 32'h1032_5476, 32'hc3d2_e1f0
  };

  // Padding marker byte and the block layout.
  localparam logic [7:0]  PAD_BYTE     = 8'h80;
  localparam int unsigned BLOCK_WORDS  = 16;
  localparam logic [3:0]  LEN_HI_IDX   = 4'd14;
  localparam logic [3:0]  LEN_LO_IDX   = 4'd15;
  localparam logic [5:0]  LAST_FILL    = 6'd63;
  localparam logic [5:0]  LEN_FILL     = 6'd56;

  // Round numbering.
  localparam logic [6:0]  LAST_ROUND   = 7'd79;
  localparam logic [6:0]  ROUND_G1     = 7'd20;
  localparam logic [6:0]  ROUND_G2     = 7'd40;
  localparam logic [6:0]  ROUND_G3     = 7'd60;

  // Digest word numbering and the largest byte count of a word.
  localparam logic [2:0]  LAST_DIGEST_IDX = 3'd4;
  localparam logic [2:0]  MAX_BYTES       = 3'd4;

endpackage

>>> hdl/sha1_if.sv
// Handshake channel interfaces for message words and digest words.
interface sha1_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic        last;

  modport source (output valid, output data_word, output byte_count, output last,
                  input ready);
  modport sink   (input valid, input data_word, input byte_count, input last,
                  output ready);
endinterface

interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

>>> hdl/sha1_hash_engine.sv
// Streaming SHA-1 engine: byte gathering, padding, round sequencer and digest output.
//
// Usage: message words arrive on in_chan as big-endian 32-bit words with a count
// of valid left-aligned bytes (counts above four act as four) and a last flag.
// A zero count is meant for a last word only; on a non-last word it adds nothing.
// When the last word has been taken, the five digest words leave on out_chan in
// order, word_index 0 to 4, with last_word set on the fifth, and the engine
// starts a fresh message.
// Flow: in_chan is ready only when the engine is idle, so a new word is taken
// only after the previous one is fully absorbed. Bytes are placed one at a time;
// each full 64-byte block is compressed by the single round unit, followed by
// the chaining add. The last word then pads the block with zero words (and an
// extra block when the length needs one) and runs one or two further
// compressions before the first digest word shows.
// Reset loads the initial chaining values and clears the fill level and the byte count.
// A stalled receiver holds the current digest word on out_chan; nothing else
// moves until that transfer completes.
module sha1_hash_engine
  import sha1_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  sha1_in_if.sink         in_chan,
  sha1_out_if.source      out_chan
);

  sha1_state_t state_r, state_nxt;

  logic [31:0] data_r, data_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        last_r, last_nxt;
  logic [2:0]  bi_r, bi_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [60:0] nbytes_r, nbytes_nxt;
  logic [3:0]  wp_r, wp_nxt;
  logic        extra_r, extra_nxt;
  logic        final_r, final_nxt;
  logic        pad_r, pad_nxt;
  logic [6:0]  rnd_r, rnd_nxt;
  logic [2:0]  oidx_r, oidx_nxt;
  logic [31:0] w_r [BLOCK_WORDS];
  logic [31:0] w_nxt [BLOCK_WORDS];
  logic [31:0] h_r [CHAIN_WORDS];
  logic [31:0] h_nxt [CHAIN_WORDS];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;

  // Round datapath: one SHA-1 round and one schedule word per cycle.
  logic [31:0] f_rnd, k_rnd, t_rnd, sched_x, sched_new;

  always_comb begin
    if (rnd_r < ROUND_G1) begin
      f_rnd = (b_r & c_r) | (~b_r & d_r);
      k_rnd = K_R0;
    end else if (rnd_r < ROUND_G2) begin
      f_rnd = b_r ^ c_r ^ d_r;
      k_rnd = K_R1;
    end else if (rnd_r < ROUND_G3) begin
      f_rnd = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k_rnd = K_R2;
    end else begin
      f_rnd = b_r ^ c_r ^ d_r;
      k_rnd = K_R3;
    end
    t_rnd     = {a_r[26:0], a_r[31:27]} + f_rnd + e_r + k_rnd + w_r[0];
    sched_x   = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
    sched_new = {sched_x[30:0], sched_x[31]};
  end

  // Byte placement: the new byte goes to its lane, lower lanes are cleared.
  logic [7:0]  cur_byte;
  logic [31:0] cur_shifted;
  logic        put_en;
  logic [7:0]  put_val;
  logic [4:0]  lane_sh;
  logic [31:0] keep_mask;

  assign cur_shifted = data_r << {bi_r[1:0], 3'b000};
  assign cur_byte    = cur_shifted[31:24];
  assign lane_sh     = {fill_r[1:0], 3'b000};
  assign keep_mask   = ~(32'hffff_ffff >> lane_sh);

  // Channel outputs.
  assign in_chan.ready        = (state_r == ST_IDLE);
  assign out_chan.valid       = (state_r == ST_OUT);
  assign out_chan.digest_word = h_r[0];
  assign out_chan.word_index  = oidx_r;
  assign out_chan.last_word   = (oidx_r == LAST_DIGEST_IDX);

  // Sequencer: next state and next register values.
  always_comb begin
    state_nxt  = state_r;
    data_nxt   = data_r;
    cnt_nxt    = cnt_r;
    last_nxt   = last_r;
    bi_nxt     = bi_r;
    fill_nxt   = fill_r;
    nbytes_nxt = nbytes_r;
    wp_nxt     = wp_r;
    extra_nxt  = extra_r;
    final_nxt  = final_r;
    pad_nxt    = pad_r;
    rnd_nxt    = rnd_r;
    oidx_nxt   = oidx_r;
    w_nxt      = w_r;
    h_nxt      = h_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    c_nxt      = c_r;
    d_nxt      = d_r;
    e_nxt      = e_r;
    put_en     = 1'b0;
    put_val    = cur_byte;

    unique case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          data_nxt  = in_chan.data_word;
          cnt_nxt   = (in_chan.byte_count > MAX_BYTES) ? MAX_BYTES : in_chan.byte_count;
          last_nxt  = in_chan.last;
          bi_nxt    = 3'd0;
          state_nxt = ST_ABSORB;
        end
      end

      ST_ABSORB: begin
        if (bi_r < cnt_r) begin
          put_en     = 1'b1;
          fill_nxt   = fill_r + 6'd1;
          nbytes_nxt = nbytes_r + 61'd1;
          bi_nxt     = bi_r + 3'd1;
          if (fill_r == LAST_FILL) begin
            // Block complete: compress before the next byte.
            pad_nxt   = 1'b0;
            final_nxt = 1'b0;
            rnd_nxt   = 7'd0;
            a_nxt     = h_r[0];
            b_nxt     = h_r[1];
            c_nxt     = h_r[2];
            d_nxt     = h_r[3];
            e_nxt     = h_r[4];
            state_nxt = ST_ROUND;
          end
        end else if (last_r) begin
          // End of message: marker byte, then zero words up to the length.
          put_en    = 1'b1;
          put_val   = PAD_BYTE;
          wp_nxt    = fill_r[5:2] + 4'd1;
          extra_nxt = (fill_r >= LEN_FILL);
          pad_nxt   = 1'b1;
          state_nxt = ST_ZERO;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_ZERO: begin
        if (extra_r && wp_r == 4'd0) begin
          // No room for the length: compress this block first.
          extra_nxt = 1'b0;
          final_nxt = 1'b0;
          rnd_nxt   = 7'd0;
          a_nxt     = h_r[0];
          b_nxt     = h_r[1];
          c_nxt     = h_r[2];
          d_nxt     = h_r[3];
          e_nxt     = h_r[4];
          state_nxt = ST_ROUND;
        end else if (!extra_r && wp_r == LEN_HI_IDX) begin
          state_nxt = ST_LEN;
        end else begin
          w_nxt[wp_r] = 32'd0;
          wp_nxt      = wp_r + 4'd1;
        end
      end

      ST_LEN: begin
        w_nxt[LEN_HI_IDX] = {nbytes_r[60:29]};
        w_nxt[LEN_LO_IDX] = {nbytes_r[28:0], 3'b000};
        final_nxt = 1'b1;
        rnd_nxt   = 7'd0;
        a_nxt     = h_r[0];
        b_nxt     = h_r[1];
        c_nxt     = h_r[2];
        d_nxt     = h_r[3];
        e_nxt     = h_r[4];
        state_nxt = ST_ROUND;
      end

      ST_ROUND: begin
        for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
          w_nxt[i] = w_r[i + 1];
        end
        w_nxt[BLOCK_WORDS - 1] = sched_new;
        a_nxt   = t_rnd;
        b_nxt   = a_r;
        c_nxt   = {b_r[1:0], b_r[31:2]};
        d_nxt   = c_r;
        e_nxt   = d_r;
        rnd_nxt = rnd_r + 7'd1;
        if (rnd_r == LAST_ROUND) begin
          state_nxt = ST_FINISH;
        end
      end

      ST_FINISH: begin
        h_nxt[0] = h_r[0] + a_r;
        h_nxt[1] = h_r[1] + b_r;
        h_nxt[2] = h_r[2] + c_r;
        h_nxt[3] = h_r[3] + d_r;
        h_nxt[4] = h_r[4] + e_r;
        if (final_r) begin
          oidx_nxt  = 3'd0;
          state_nxt = ST_OUT;
        end else if (pad_r) begin
          state_nxt = ST_ZERO;
        end else begin
          state_nxt = ST_ABSORB;
        end
      end

      ST_OUT: begin
        if (out_chan.ready) begin
          if (oidx_r == LAST_DIGEST_IDX) begin
            // Digest delivered: fresh message state.
            h_nxt      = H_INIT;
            fill_nxt   = 6'd0;
            nbytes_nxt = 61'd0;
            pad_nxt    = 1'b0;
            final_nxt  = 1'b0;
            oidx_nxt   = 3'd0;
            state_nxt  = ST_IDLE;
          end else begin
            for (int i = 0; i < CHAIN_WORDS - 1; i++) begin
              h_nxt[i] = h_r[i + 1];
            end
            h_nxt[CHAIN_WORDS - 1] = h_r[0];
            oidx_nxt = oidx_r + 3'd1;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // Byte write into the block store at the current fill position.
    if (put_en) begin
      w_nxt[fill_r[5:2]] = (w_r[fill_r[5:2]] & keep_mask) | ({put_val, 24'd0} >> lane_sh);
    end
  end

  // Control and chaining registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      bi_r     <= 3'd0;
      fill_r   <= 6'd0;
      nbytes_r <= 61'd0;
      wp_r     <= 4'd0;
      extra_r  <= 1'b0;
      final_r  <= 1'b0;
      pad_r    <= 1'b0;
      rnd_r    <= 7'd0;
      oidx_r   <= 3'd0;
      h_r      <= H_INIT;
    end else begin
      state_r  <= state_nxt;
      bi_r     <= bi_nxt;
      fill_r   <= fill_nxt;
      nbytes_r <= nbytes_nxt;
      wp_r     <= wp_nxt;
      extra_r  <= extra_nxt;
      final_r  <= final_nxt;
      pad_r    <= pad_nxt;
      rnd_r    <= rnd_nxt;
      oidx_r   <= oidx_nxt;
      h_r      <= h_nxt;
    end
  end

  // Payload registers: captured word, block store and working variables.
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    cnt_r  <= cnt_nxt;
    last_r <= last_nxt;
    w_r    <= w_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    c_r    <= c_nxt;
    d_r    <= d_nxt;
    e_r    <= e_nxt;
  end

endmodule

>>> hdl/sha1_checker.sv
// Port-level checks of the SHA-1 engine and their binding to the top level.
module sha1_checker
  import sha1_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] digest_word,
  input logic [2:0]  word_index,
  input logic        last_word
);

  // The engine never takes a word while a digest is being delivered.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while digest words are pending");

  // The final flag marks the fifth digest word and no other.
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (last_word == (word_index == LAST_DIGEST_IDX)))
    else $error("last_word disagrees with word_index");

  // Digest words follow one another in order without a gap.
  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !last_word) |=>
      (out_valid && word_index == $past(word_index) + 3'd1))
    else $error("digest word sequence broken");

  // After the final digest transfer the engine is idle again.
  a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && last_word) |=> (in_ready && !out_valid))
    else $error("engine not idle after digest");

  // A stalled digest word holds its value.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(digest_word) && $stable(word_index)))
    else $error("digest word changed under stall");

endmodule

bind sha1_hash_engine sha1_checker u_sha1_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .digest_word (out_chan.digest_word),
  .word_index  (out_chan.word_index),
  .last_word   (out_chan.last_word)
);

>>> tb/sha1_digest_checker.sv
// Checker for the SHA-1 engine: tracks message words, predicts digests and compares them.
module sha1_digest_checker
  import sha1_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  sha1_in_if          in_mon,
  sha1_out_if         out_mon,
  output int unsigned err_count,
  output int unsigned digests_pending
);

  timeunit 1ns;
  timeprecision 1ps;

  // One expected digest word as it should appear on the result channel.
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_beat_t;

  digest_beat_t digest_due[$];

  // Predicted engine state: chaining words, block buffer, fill level, bit length.
  logic [31:0] chain [CHAIN_WORDS];
  logic [31:0] blk [BLOCK_WORDS];
  logic [5:0]  fill;
  logic [63:0] bit_total;

  // Eighty rounds over the buffered block, folded into the chaining words.
  function automatic void run_compression();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t, x;
    for (int r = 0; r < 16; r++) w[r] = blk[r];
    for (int r = 16; r < 80; r++) begin
      x = w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16];
      w[r] = {x[30:0], x[31]};
    end
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
    for (int r = 0; r < 80; r++) begin
      if (r < ROUND_G1) begin
        f = (b & c) | (~b & d);
        k = K_R0;
      end else if (r < ROUND_G2) begin
        f = b ^ c ^ d;
        k = K_R1;
      end else if (r < ROUND_G3) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_R2;
      end else begin
        f = b ^ c ^ d;
        k = K_R3;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[r];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
  endfunction

  // Write one byte at the current fill position; the 6-bit fill wraps per block.
  function automatic void place_byte(logic [7:0] val);
    int sh;
    sh = 24 - 8 * fill[1:0];
    blk[fill[5:2]][sh +: 8] = val;
    fill = fill + 6'd1;
  endfunction

  function automatic void clear_message();
    chain = H_INIT;
    fill = '0;
    bit_total = '0;
  endfunction

  // Absorb one message word; on the last word pad, finish and queue the digest.
  function automatic void predict_word(logic [31:0] data, logic [2:0] cnt, logic lst);
    int n;
    digest_beat_t beat;
    n = (cnt > MAX_BYTES) ? MAX_BYTES : cnt;
    for (int i = 0; i < n; i++) begin
      place_byte(data[31-8*i -: 8]);
      bit_total += 64'd8;
      if (fill == '0) run_compression();
    end
    if (!lst) return;
    place_byte(PAD_BYTE);
    // No room left for the length field: flush a padding block first.
    if (fill > LEN_FILL || fill == '0) begin
      while (fill != '0) place_byte(8'h00);
      run_compression();
    end
    while (fill < LEN_FILL) place_byte(8'h00);
    blk[LEN_HI_IDX] = bit_total[63:32];
    blk[LEN_LO_IDX] = bit_total[31:0];
    run_compression();
    for (int i = 0; i < CHAIN_WORDS; i++) begin
      beat.digest_word = chain[i];
      beat.word_index  = 3'(i);
      beat.last_word   = (3'(i) == LAST_DIGEST_IDX);
      digest_due.push_back(beat);
    end
    clear_message();
  endfunction

  // Sample both channels at the rising edge; results are checked before new words.
  always @(posedge clk) begin
    digest_beat_t want;
    if (!rst_n) begin
      clear_message();
      for (int i = 0; i < BLOCK_WORDS; i++) blk[i] = '0;
      digest_due.delete();
      err_count <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (digest_due.size() == 0) begin
          $error("unexpected digest word transfer: digest_word %h word_index %0d",
                 out_mon.digest_word, out_mon.word_index);
          err_count <= err_count + 1;
        end else begin
          want = digest_due.pop_front();
          if (out_mon.digest_word !== want.digest_word ||
              out_mon.word_index !== want.word_index ||
              out_mon.last_word !== want.last_word) begin
            err_count <= err_count + 1;
          end
          if (out_mon.digest_word !== want.digest_word)
            $error("digest_word: expected %h, got %h", want.digest_word, out_mon.digest_word);
          if (out_mon.word_index !== want.word_index)
            $error("word_index: expected %0d, got %0d", want.word_index, out_mon.word_index);
          if (out_mon.last_word !== want.last_word)
            $error("last_word: expected %b, got %b", want.last_word, out_mon.last_word);
        end
      end
      if (in_mon.valid && in_mon.ready)
        predict_word(in_mon.data_word, in_mon.byte_count, in_mon.last);
    end
    digests_pending <= digest_due.size();
  end

endmodule

>>> tb/sha1_hash_engine_tb.sv
// Testbench top for the SHA-1 engine: clock, reset, message stimulus and the verdict.
module sha1_hash_engine_tb
  import sha1_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_WORDS = 360;
  localparam int unsigned QUIET_FROM   = 140;
  localparam int unsigned QUIET_TO     = 230;
  localparam int unsigned DRAIN_CYCLES = 200;

  logic clk;
  logic rst_n;
  logic quiet;
  int unsigned err_count;
  int unsigned digests_pending;
  int unsigned words_sent;

  sha1_in_if  in_chan ();
  sha1_out_if out_chan ();

  sha1_hash_engine dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  sha1_digest_checker checker_inst (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_chan),
    .out_mon         (out_chan),
    .err_count       (err_count),
    .digests_pending (digests_pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Digest receiver: stalls now and then, never during the quiet stretch.
  always @(negedge clk) begin
    out_chan.ready <= quiet || ($urandom_range(0, 99) >= 11);
  end

  // Offer one word, possibly after a random gap, and hold it until the transfer.
  task automatic send_word(input logic [31:0] data, input logic [2:0] cnt,
                           input logic lst);
    while (!quiet && $urandom_range(0, 99) < 11) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.data_word  <= data;
    in_chan.byte_count <= cnt;
    in_chan.last       <= lst;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
    if (cnt != 3'd0 || lst) words_sent++;
  endtask

  // A random message: mostly full words, some short, empty or oversized counts.
  task automatic send_message(input int unsigned n_words);
    logic [2:0] cnt;
    for (int i = 0; i < n_words; i++) begin
      quiet = (words_sent >= QUIET_FROM && words_sent < QUIET_TO);
      if (i == n_words - 1)
        cnt = 3'($urandom_range(0, 7));
      else
        cnt = ($urandom_range(0, 99) < 80) ? MAX_BYTES : 3'($urandom_range(0, 7));
      send_word($urandom, cnt, i == n_words - 1);
    end
  endtask

  // Stimulus: directed messages, then random ones, then drain and verdict.
  initial begin
    int pick;
    quiet = 1'b0;
    words_sent = 0;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.data_word = '0;
    in_chan.byte_count = '0;
    in_chan.last = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Empty message, then the classic three-byte message.
    send_word(32'h0000_0000, 3'd0, 1'b1);
    send_word(32'h6162_6300, 3'd3, 1'b1);
    // Byte counts above four behave as four.
    send_word(32'hffff_ffff, 3'd5, 1'b0);
    send_word(32'h0000_0000, 3'd6, 1'b0);
    send_word(32'hffff_ffff, 3'd7, 1'b1);
    // An empty word inside a message adds nothing.
    send_word(32'hdead_beef, 3'd0, 1'b0);
    send_word(32'h8000_0000, 3'd1, 1'b1);
    // Fifty-six bytes leave no room for the length: an extra block follows.
    for (int i = 0; i < 13; i++) send_word($urandom, MAX_BYTES, 1'b0);
    send_word($urandom, MAX_BYTES, 1'b1);

    // Random messages, mostly short, a few spanning several blocks.
    while (words_sent < RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)
        send_message($urandom_range(1, 8));
      else if (pick < 95)
        send_message($urandom_range(9, 20));
      else
        send_message($urandom_range(21, 40));
    end
    quiet = 1'b0;
    in_chan.valid <= 1'b0;

    while (digests_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog for a hung engine or digests that never arrive.
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
